// ===== rtl/cda_pkg.sv =====
// shared types, constants and calendar helper functions for the date advance block
// no dependencies
package cda_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int YEAR_WIDTH_DEF  = 16;

   localparam int COUNT_PORT_W = 16;
   localparam int YEAR_PORT_W  = 16;
   localparam int DAY_W        = 5;
   localparam int MONTH_W      = 4;
   localparam int MONEY_W      = 32;

   localparam int CYCLE_YEARS     = 400;
   localparam int CENTURY_YEARS   = 100;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int FEB_LEAP_DAYS   = 29;
   localparam int FEB_DAYS        = 28;
   localparam int FEBRUARY        = 2;
   localparam int JULY            = 7;

   // remainder of the shared divider, wide enough for anything below 400
   localparam int DIV_REM_W = 9;
   localparam int DIV_IN_W  = 32;
   localparam int DIV_MUL_W = 30;
   localparam int DIV_QUO_W = 30;

   // rounded-up reciprocals of 3 and 25 with their shifts
   localparam int RECIP_3        = 715827883;
   localparam int RECIP_3_SHIFT  = 31;
   localparam int RECIP_25       = 42949673;
   localparam int RECIP_25_SHIFT = 30;

   typedef enum logic [1:0] {
      OP_DAYS   = 2'd0,
      OP_MONTHS = 2'd1,
      OP_SET    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef logic signed [MONEY_W-1:0] income_type;

   typedef struct packed {
      logic [1:0]              op;
      logic [COUNT_PORT_W-1:0] count;
      logic [DAY_W-1:0]        new_day;
      logic [MONTH_W-1:0]      new_month;
      logic [YEAR_PORT_W-1:0]  new_year;
   } req_payload_type;

   typedef struct packed {
      logic [DAY_W-1:0]         day;
      logic [MONTH_W-1:0]       month;
      logic [YEAR_PORT_W-1:0]   year;
      logic signed [MONEY_W-1:0] money;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic sel400;
   } div_ctl_type;

   function automatic logic leap_from_residue(input logic [DIV_REM_W-1:0] r);
      return (r[1:0] == 2'b00 && r != DIV_REM_W'(CENTURY_YEARS)
              && r != DIV_REM_W'(2 * CENTURY_YEARS)
              && r != DIV_REM_W'(3 * CENTURY_YEARS))
             || r == '0;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      if (m == MONTH_W'(FEBRUARY)) begin
         len = leap ? DAY_W'(FEB_LEAP_DAYS) : DAY_W'(FEB_DAYS);
      end else if (m <= MONTH_W'(JULY)) begin
         len = m[0] ? DAY_W'(31) : DAY_W'(30);
      end else begin
         len = m[0] ? DAY_W'(30) : DAY_W'(31);
      end
      return len;
   endfunction

endpackage

// ===== rtl/cda_chan_if.sv =====
// valid/ready channel carrying one item of a given payload type
// no dependencies
interface cda_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/cda_div_unit.sv =====
// shared divide unit: quotient and remainder by 12, or remainder by 400, in the cycle
// after a load, by reciprocal multiplication; depends on cda_pkg
module cda_div_unit (
   input  logic                            clock,
   input  cda_pkg::div_ctl_type            ctl,
   input  logic [cda_pkg::DIV_IN_W-1:0]    dividend,
   output logic [cda_pkg::DIV_QUO_W-1:0]   quo,
   output logic [cda_pkg::DIV_REM_W-1:0]   rem
);
   import cda_pkg::*;

   logic [DIV_MUL_W-1:0]   mul_a;
   logic [DIV_MUL_W-1:0]   mul_b;
   logic [2*DIV_MUL_W-1:0] prod_ff, prod_in;
   logic [DIV_REM_W-1:0]   low_ff, low_in;
   logic                   sel_ff, sel_in;
   logic [DIV_REM_W-1:0]   back;

   // x/12 is (x/4)/3 and x/400 is (x/16)/25
   assign mul_a = ctl.sel400 ? DIV_MUL_W'(dividend >> 4) : DIV_MUL_W'(dividend >> 2);
   assign mul_b = ctl.sel400 ? DIV_MUL_W'(RECIP_25) : DIV_MUL_W'(RECIP_3);

   always_comb begin
      prod_in = prod_ff;
      low_in  = low_ff;
      sel_in  = sel_ff;
      if (ctl.load) begin
         prod_in = mul_a * mul_b;
         low_in  = dividend[DIV_REM_W-1:0];
         sel_in  = ctl.sel400;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      low_ff  <= low_in;
      sel_ff  <= sel_in;
   end

   assign quo  = sel_ff ? DIV_QUO_W'(prod_ff >> RECIP_25_SHIFT)
                        : DIV_QUO_W'(prod_ff >> RECIP_3_SHIFT);
   // remainder needs only the low bits of quotient times divisor
   assign back = sel_ff ? DIV_REM_W'((quo << 8) + (quo << 7) + (quo << 4))
                        : DIV_REM_W'((quo << 3) + (quo << 2));
   assign rem  = low_ff - back;
endmodule

// ===== rtl/calendar_date_advance.sv =====
// top level of the gregorian date counter with monthly money accumulator
// depends on cda_pkg, cda_chan_if and cda_div_unit
//
// usage:
//   req_chan carries one item (op, count, new_day, new_month, new_year); req ready
//   is high only while the sequencer is idle. rsp_chan returns one item per request
//   holding day, month, year and money after the step. csr_chan writes
//   monthly_income and is always ready; it must be written only while the block
//   is idle, which the block does not enforce. steps from accept to result:
//   advance days:   walk the months crossed
//   advance months: income product and month split, year update, year residue, walk
//   set date:       year residue, day clamp
//   unused op:      none
//   one item at a time; the next request is taken once the block is back in idle
//   after the result loads. a day advance walks one month per cycle, the income
//   product takes one count bit per cycle, month split and year residue take one pass
//   each through the shared reciprocal divide-by-12/400 unit.
// reset: date 1/1/1, money 0, income 0, no result pending.
// a stalled receiver holds the result register; the block still takes the next
// request and stops only in its final state until the register is free.
module calendar_date_advance #(
   parameter int COUNT_WIDTH = cda_pkg::COUNT_WIDTH_DEF,
   parameter int YEAR_WIDTH  = cda_pkg::YEAR_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   cda_chan_if.sink   req_chan,
   cda_chan_if.source rsp_chan,
   cda_chan_if.sink   csr_chan
);
   import cda_pkg::*;

   localparam int CNT_W  = (COUNT_WIDTH < COUNT_PORT_W) ? COUNT_WIDTH : COUNT_PORT_W;
   localparam int TOT_W  = CNT_W + 1;
   localparam int ACC_W  = ((CNT_W > DAY_W) ? CNT_W : DAY_W) + 1;
   localparam int SUM_W  = ((TOT_W > YEAR_WIDTH) ? TOT_W : YEAR_WIDTH) + 1;
   localparam int NY_W   = (YEAR_WIDTH > YEAR_PORT_W) ? YEAR_WIDTH : YEAR_PORT_W;
   localparam int STEP_W = $clog2(TOT_W + 1);
   localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = '1;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_MULDIV  = 8'b0000_0010,
      ST_YEARUPD = 8'b0000_0100,
      ST_MODY    = 8'b0000_1000,
      ST_LOADR   = 8'b0001_0000,
      ST_CLAMP   = 8'b0010_0000,
      ST_WALK    = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [DAY_W-1:0]      day_ff, day_in;
   logic [MONTH_W-1:0]    month_ff, month_in;
   logic [YEAR_WIDTH-1:0] year_ff, year_in;
   logic [MONEY_W-1:0]    money_ff, money_in;
   logic [MONEY_W-1:0]    income_ff, income_in;
   logic [DIV_REM_W-1:0]  r400_ff, r400_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [TOT_W-1:0]      tot_ff, tot_in;
   logic [TOT_W-1:0]      cnt_ff, cnt_in;
   logic [MONEY_W-1:0]    prod_ff, prod_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   op_type                op_ff, op_in;
   rsp_payload_type       rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_accept;
   logic                  rsp_load;
   logic [CNT_W-1:0]      req_cnt;
   logic [MONTH_W-1:0]    set_month;
   logic [YEAR_WIDTH-1:0] set_year;
   logic [NY_W-1:0]       ny_ext;
   logic [SUM_W-1:0]      ysum;
   logic [YEAR_WIDTH-1:0] ynew;
   logic [DAY_W-1:0]      month_days;

   div_ctl_type           div_ctl;
   logic [DIV_IN_W-1:0]   div_dividend;
   logic [DIV_QUO_W-1:0]  div_quo;
   logic [DIV_REM_W-1:0]  div_rem;

   cda_div_unit u_div (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign req_cnt      = CNT_W'(req_chan.payload.count);
   assign month_days   = month_len(month_ff, leap_from_residue(r400_ff));
   assign ny_ext       = NY_W'(req_chan.payload.new_year);
   assign div_dividend = div_ctl.sel400 ? DIV_IN_W'(year_ff) : DIV_IN_W'(tot_ff);
   assign ysum         = SUM_W'(year_ff) + SUM_W'(div_quo[TOT_W-1:0]);
   assign ynew         = (ysum > SUM_W'(YEAR_MAX)) ? YEAR_MAX : ysum[YEAR_WIDTH-1:0];

   always_comb begin
      if (req_chan.payload.new_month == '0) begin
         set_month = MONTH_W'(1);
      end else if (req_chan.payload.new_month > MONTH_W'(MONTHS_PER_YEAR)) begin
         set_month = MONTH_W'(MONTHS_PER_YEAR);
      end else begin
         set_month = req_chan.payload.new_month;
      end
      if (ny_ext > NY_W'(YEAR_MAX)) begin
         set_year = YEAR_MAX;
      end else begin
         set_year = YEAR_WIDTH'(ny_ext);
      end
   end

   always_comb begin
      state_in  = state_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      money_in  = money_ff;
      income_in = income_ff;
      r400_in   = r400_ff;
      acc_in    = acc_ff;
      tot_in    = tot_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      step_in   = step_ff;
      op_in     = op_ff;
      div_ctl   = '0;
      rsp_load  = 1'b0;

      if (csr_chan.valid) begin
         income_in = csr_chan.payload;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in = op_type'(req_chan.payload.op);
               case (op_type'(req_chan.payload.op))
                  OP_DAYS: begin
                     acc_in   = ACC_W'(day_ff) + ACC_W'(req_cnt);
                     state_in = ST_WALK;
                  end
                  OP_MONTHS: begin
                     tot_in   = TOT_W'(month_ff - MONTH_W'(1)) + TOT_W'(req_cnt);
                     cnt_in   = TOT_W'(req_cnt);
                     prod_in  = '0;
                     step_in  = STEP_W'(TOT_W);
                     state_in = ST_MULDIV;
                  end
                  OP_SET: begin
                     month_in = set_month;
                     year_in  = set_year;
                     day_in   = req_chan.payload.new_day;
                     state_in = ST_MODY;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MULDIV: begin
            // month split in the divide unit, income product one bit per cycle
            div_ctl.load = 1'b1;
            prod_in      = (prod_ff << 1) + (cnt_ff[TOT_W-1] ? income_ff : '0);
            cnt_in       = cnt_ff << 1;
            step_in      = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_YEARUPD;
            end
         end
         ST_YEARUPD: begin
            month_in = MONTH_W'(div_rem) + MONTH_W'(1);
            money_in = money_ff + prod_ff;
            year_in  = ynew;
            acc_in   = ACC_W'(day_ff);
            state_in = ST_MODY;
         end
         ST_MODY: begin
            // year mod 400 for the leap rule
            div_ctl.load   = 1'b1;
            div_ctl.sel400 = 1'b1;
            state_in       = ST_LOADR;
         end
         ST_LOADR: begin
            r400_in  = div_rem;
            state_in = (op_ff == OP_SET) ? ST_CLAMP : ST_WALK;
         end
         ST_CLAMP: begin
            if (day_ff == '0) begin
               day_in = DAY_W'(1);
            end else if (day_ff > month_days) begin
               day_in = month_days;
            end
            state_in = ST_DONE;
         end
         ST_WALK: begin
            // one month per cycle
            if (acc_ff > ACC_W'(month_days)) begin
               acc_in   = acc_ff - ACC_W'(month_days);
               money_in = money_ff + income_ff;
               if (month_ff == MONTH_W'(MONTHS_PER_YEAR)) begin
                  month_in = MONTH_W'(1);
                  if (year_ff != YEAR_MAX) begin
                     year_in = year_ff + YEAR_WIDTH'(1);
                     r400_in = (r400_ff == DIV_REM_W'(CYCLE_YEARS - 1))
                               ? '0 : r400_ff + DIV_REM_W'(1);
                  end
               end else begin
                  month_in = month_ff + MONTH_W'(1);
               end
            end else begin
               day_in   = acc_ff[DAY_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.day   = day_ff;
         rsp_in.month = month_ff;
         rsp_in.year  = YEAR_PORT_W'(year_ff);
         rsp_in.money = money_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         day_ff       <= DAY_W'(1);
         month_ff     <= MONTH_W'(1);
         year_ff      <= YEAR_WIDTH'(1);
         money_ff     <= '0;
         income_ff    <= '0;
         r400_ff      <= DIV_REM_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         money_ff     <= money_in;
         income_ff    <= income_in;
         r400_ff      <= r400_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      tot_ff  <= tot_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
      op_ff   <= op_in;
      rsp_ff  <= rsp_in;
   end

`ifndef SYNTH
   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      r400_ff < DIV_REM_W'(CYCLE_YEARS))
      else $error("year residue out of range");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      month_ff >= MONTH_W'(1) && month_ff <= MONTH_W'(MONTHS_PER_YEAR))
      else $error("month out of range");

   a_idle_day: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (day_ff != '0 && day_ff <= month_days))
      else $error("day does not fit month while idle");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_chan.ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result item not presented");

   a_year_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && year_ff == YEAR_MAX) |=> year_ff == YEAR_MAX)
      else $error("saturated year moved");
`endif
endmodule

// ===== test/calendar_date_advance_checker.sv =====
`timescale 1ns / 1ps
// checker for calendar_date_advance: tracks date, money and income from accepted items
// and compares every result item field by field; depends on cda_pkg
module calendar_date_advance_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  cda_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  cda_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  cda_pkg::income_type      csr_payload,
   output int                       mismatches,
   output int                       outstanding
);
   import cda_pkg::*;

   localparam int unsigned     YEAR_TOP   = (1 << YEAR_WIDTH_DEF) - 1;
   localparam longint unsigned DAYS_400   = 146097;
   localparam longint unsigned MONTHS_400 = 4800;

   int unsigned     cal_day;
   int unsigned     cal_month;
   int unsigned     cal_year;
   logic [31:0]     purse;
   logic [31:0]     income;
   rsp_payload_type date_q[$];

   function automatic bit is_leap(input int unsigned y);
      return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
   endfunction

   function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
      if (m == 2) begin
         return is_leap(y) ? 29 : 28;
      end
      if (m <= 7) begin
         return (m % 2 == 1) ? 31 : 30;
      end
      return (m % 2 == 1) ? 30 : 31;
   endfunction

   task automatic credit_months(input longint unsigned n);
      purse = purse + 32'(n) * income;
   endtask

   task automatic step_month;
      credit_months(1);
      if (cal_month >= 12) begin
         cal_month = 1;
         if (cal_year < YEAR_TOP) begin
            cal_year++;
         end
      end else begin
         cal_month++;
      end
   endtask

   // acc counts days from the start of the current month
   task automatic roll_days(input longint unsigned acc);
      longint unsigned n;
      longint unsigned lim;
      longint unsigned ylen;
      if (acc > DAYS_400 + 31 && cal_year < YEAR_TOP) begin
         n = (acc - 31) / DAYS_400;
         lim = (YEAR_TOP - cal_year) / 400;
         if (n > lim) begin
            n = lim;
         end
         acc -= n * DAYS_400;
         cal_year = 32'(cal_year + 400 * n);
         credit_months(n * MONTHS_400);
      end
      while (acc > days_in(cal_month, cal_year)) begin
         ylen = is_leap(cal_year) ? 366 : 365;
         if (cal_year == YEAR_TOP && acc > ylen + 31) begin
            // year pinned at its top: skip whole years at once
            n = (acc - 31) / ylen;
            acc -= n * ylen;
            credit_months(n * 12);
         end else begin
            acc -= days_in(cal_month, cal_year);
            step_month();
         end
      end
      cal_day = 32'(acc);
   endtask

   task automatic apply_request(input req_payload_type r, output rsp_payload_type res);
      longint unsigned total;
      int unsigned     nd;
      int unsigned     nm;
      int unsigned     len;
      case (r.op)
         OP_DAYS: begin
            total = cal_day;
            roll_days(total + r.count);
         end
         OP_MONTHS: begin
            credit_months(r.count);
            total = cal_month - 1;
            total += r.count;
            cal_month = 32'(total % 12 + 1);
            total = total / 12;
            if (total > YEAR_TOP - cal_year) begin
               cal_year = YEAR_TOP;
            end else begin
               cal_year = 32'(cal_year + total);
            end
            roll_days(cal_day);
         end
         OP_SET: begin
            nm = r.new_month;
            if (nm < 1) begin
               nm = 1;
            end
            if (nm > 12) begin
               nm = 12;
            end
            cal_month = nm;
            cal_year = (r.new_year > YEAR_TOP) ? YEAR_TOP : r.new_year;
            len = days_in(cal_month, cal_year);
            nd = r.new_day;
            if (nd < 1) begin
               nd = 1;
            end
            if (nd > len) begin
               nd = len;
            end
            cal_day = nd;
         end
         default: begin
         end
      endcase
      res.day   = 5'(cal_day);
      res.month = 4'(cal_month);
      res.year  = 16'(cal_year);
      res.money = purse;
   endtask

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         cal_day = 1;
         cal_month = 1;
         cal_year = 1;
         purse = '0;
         income = '0;
         date_q.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (date_q.size() == 0) begin
               flag_mismatch("day of an item with nothing expected", rsp_payload.day, 0);
            end else begin
               want = date_q.pop_front();
               if (rsp_payload.day !== want.day) begin
                  flag_mismatch("day", rsp_payload.day, want.day);
               end
               if (rsp_payload.month !== want.month) begin
                  flag_mismatch("month", rsp_payload.month, want.month);
               end
               if (rsp_payload.year !== want.year) begin
                  flag_mismatch("year", rsp_payload.year, want.year);
               end
               if (rsp_payload.money !== want.money) begin
                  flag_mismatch("money", $signed(rsp_payload.money), $signed(want.money));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            income = csr_payload;
         end
         if (req_valid && req_ready) begin
            apply_request(req_payload, want);
            date_q.insert(date_q.size(), want);
         end
         outstanding <= date_q.size();
      end
   end

endmodule

// ===== test/calendar_date_advance_tb.sv =====
`timescale 1ns / 1ps
// testbench top for calendar_date_advance: clock, reset, directed and random items,
// income writes and the verdict; depends on cda_pkg, cda_chan_if and the checker
module calendar_date_advance_tb;
   import cda_pkg::*;

   localparam int IDLE_LIMIT    = 20000;
   localparam int DRAIN_CYCLES  = 64;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 200;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   req_payload_type req_data = '0;
   logic            rsp_ready = 1'b0;
   logic            csr_valid = 1'b0;
   income_type      csr_data = '0;
   bit              steady = 1'b0;
   int unsigned     rsp_hold = 0;
   int              idle_cycles = 0;
   int              mismatches;
   int              outstanding;

   cda_chan_if #(.payload_type(req_payload_type)) req_if ();
   cda_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   cda_chan_if #(.payload_type(income_type))      csr_if ();

   assign req_if.valid   = req_valid;
   assign req_if.payload = req_data;
   assign rsp_if.ready   = rsp_ready;
   assign csr_if.valid   = csr_valid;
   assign csr_if.payload = csr_data;

   calendar_date_advance u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   calendar_date_advance_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .csr_valid   (csr_if.valid),
      .csr_ready   (csr_if.ready),
      .csr_payload (csr_if.payload),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stall after each item, none in the steady phase
   always @(posedge clock) begin : receiver
      int unsigned n;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_if.valid && rsp_ready) begin
         n = steady ? 0 : $urandom_range(0, 5);
         rsp_hold <= n;
         rsp_ready <= (n == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("calendar_date_advance_tb NOT OK");
         $finish;
      end
   end

   function automatic req_payload_type make_item(input op_type op, input int unsigned count,
                                                 input int unsigned d, input int unsigned m,
                                                 input int unsigned y);
      req_payload_type p;
      p.op        = op;
      p.count     = 16'(count);
      p.new_day   = 5'(d);
      p.new_month = 4'(m);
      p.new_year  = 16'(y);
      return p;
   endfunction

   function automatic req_payload_type random_item();
      req_payload_type p;
      int unsigned     pick;
      int unsigned     spread;
      p.op        = 2'($urandom);
      p.count     = 16'($urandom);
      p.new_day   = 5'($urandom);
      p.new_month = 4'($urandom);
      p.new_year  = 16'($urandom);
      pick = $urandom_range(0, 99);
      spread = $urandom_range(0, 19);
      if (pick < 38) begin
         p.op = OP_DAYS;
         if (spread < 16) begin
            p.count = 16'($urandom_range(0, 400));
         end else if (spread < 19) begin
            p.count = 16'($urandom_range(0, 4000));
         end
      end else if (pick < 66) begin
         p.op = OP_MONTHS;
         if (spread < 14) begin
            p.count = 16'($urandom_range(0, 30));
         end else if (spread < 18) begin
            p.count = 16'($urandom_range(0, 1500));
         end
      end else if (pick < 92) begin
         p.op = OP_SET;
         case (spread % 4)
            1: p.new_year = 16'($urandom_range(1580, 2500));
            2: p.new_year = 16'($urandom_range(65400, 65535));
            3: p.new_year = 16'(400 * $urandom_range(0, 163));
            default: begin
            end
         endcase
      end else begin
         p.op = OP_NONE;
      end
      return p;
   endfunction

   task automatic send_req(input req_payload_type p);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic write_income(input income_type value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      income_type rates[RANDOM_PHASES];
      rates[0] = 32'sh8000_0000;
      rates[1] = 32'sh7FFF_FFFF;
      rates[2] = -32'sd1;
      rates[3] = income_type'($urandom);
      rates[4] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_income(32'sd1000);

      send_req(make_item(OP_NONE, 0, 0, 0, 0));
      send_req(make_item(OP_DAYS, 0, 0, 0, 0));
      send_req(make_item(OP_SET, 0, 0, 0, 0));
      send_req(make_item(OP_SET, 0, 29, 2, 1900));
      send_req(make_item(OP_SET, 0, 31, 2, 2000));
      send_req(make_item(OP_DAYS, 1, 0, 0, 0));
      send_req(make_item(OP_SET, 0, 31, 15, 2023));
      send_req(make_item(OP_DAYS, 1, 0, 0, 0));
      send_req(make_item(OP_SET, 0, 31, 1, 2024));
      send_req(make_item(OP_MONTHS, 1, 0, 0, 0));
      send_req(make_item(OP_MONTHS, 0, 0, 0, 0));
      send_req(make_item(OP_SET, 0, 31, 4, 2100));
      send_req(make_item(OP_DAYS, 65535, 0, 0, 0));
      send_req(make_item(OP_MONTHS, 65535, 0, 0, 0));
      send_req(make_item(OP_DAYS, 65535, 0, 0, 0));
      send_req(make_item(OP_MONTHS, 13, 0, 0, 0));
      send_req(make_item(OP_SET, 0, 31, 12, 65535));
      send_req(make_item(OP_DAYS, 1, 0, 0, 0));
      send_req(make_item(OP_SET, 0, 29, 2, 65535));
      send_req(make_item(OP_SET, 0, 31, 1, 65534));
      send_req(make_item(OP_MONTHS, 25, 0, 0, 0));
      send_req(make_item(OP_SET, 0, 5, 3, 1600));
      send_req(make_item(OP_NONE, 65535, 31, 15, 65535));
      wait_for_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady = (phase == 1);
         write_income(rates[phase]);
         repeat (PHASE_ITEMS) send_req(random_item());
         wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("calendar_date_advance_tb OK");
      end else begin
         $display("calendar_date_advance_tb NOT OK");
      end
      $finish;
   end

endmodule
